// ----- rtl/bws_pkg.sv -----
// Shared types and constants for the three-lane burst scheduler.
package bws_pkg;

  localparam int unsigned TASK_SLOTS  = 16;
  localparam int unsigned URG_RUN_MAX = 4;
  localparam int unsigned NRM_RUN_MAX = 2;
  localparam int unsigned NUM_LANES   = 3;

  localparam int unsigned IDX_W = $clog2(TASK_SLOTS);
  localparam int unsigned CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int unsigned POS_W = CNT_W + 1;
  localparam int unsigned UR_W  = $clog2(URG_RUN_MAX + 1);
  localparam int unsigned NR_W  = $clog2(NRM_RUN_MAX + 1);

  localparam logic [31:0] MAX_TASKS_RST = 32'd16;
  localparam logic [31:0] MAX_BYTES_RST = 32'd1048576;

  localparam logic REG_MAX_TASKS = 1'b0;
  localparam logic REG_MAX_BYTES = 1'b1;

  typedef enum logic [1:0] {
    FUNC_SUBMIT   = 2'd0,
    FUNC_DISPATCH = 2'd1,
    FUNC_COMPLETE = 2'd2,
    FUNC_INVALID  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    LANE_BG      = 2'd0,
    LANE_NORMAL  = 2'd1,
    LANE_URGENT  = 2'd2,
    LANE_INVALID = 2'd3
  } lane_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_BUDGET  = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] cost;
    logic [31:0] id;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } lane_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    entry_t           head;
  } lane_stat_t;

  typedef struct packed {
    func_e       func;
    lane_e       priority_req;
    logic [31:0] cost_bytes;
    logic [15:0] job_tag;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] task_id;
    logic [15:0] out_tag;
    logic [1:0]  out_lane;
    logic [31:0] out_cost;
    logic [4:0]  waiting_tasks;
    logic [31:0] waiting_bytes;
    logic [15:0] running_tasks;
  } rsp_t;

endpackage

// ----- rtl/bws_if.sv -----
// Request and response channel interfaces of the scheduler.
interface bws_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  priority_req;
  logic [31:0] cost_bytes;
  logic [15:0] job_tag;

  modport source (output valid, func, priority_req, cost_bytes, job_tag, input ready);
  modport sink (input valid, func, priority_req, cost_bytes, job_tag, output ready);
endinterface

interface bws_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] task_id;
  logic [15:0] out_tag;
  logic [1:0]  out_lane;
  logic [31:0] out_cost;
  logic [4:0]  waiting_tasks;
  logic [31:0] waiting_bytes;
  logic [15:0] running_tasks;

  modport source (output valid, status, task_id, out_tag, out_lane, out_cost,
                  waiting_tasks, waiting_bytes, running_tasks, input ready);
  modport sink (input valid, status, task_id, out_tag, out_lane, out_cost,
                waiting_tasks, waiting_bytes, running_tasks, output ready);
endinterface

// ----- rtl/burst_weighted_three_lane_scheduler.sv -----
// Top level: request register, scheduling pass, result register and config port.
//
// Three-lane task scheduler (background, normal, urgent) with burst limits.
// It takes one transaction per clock cycle unless the response side stalls,
// and returns one result for each: a request is captured in an input
// register, the admission check or lane selection runs in a single pass
// over the lane heads and counters, and the result lands in an output
// register. A stalled result holds; one more request can still be taken
// into an empty input register. The lane stores need no clearing after reset.
// Registers: max_queued_tasks at byte address 0, max_queued_bytes at byte
// address 4; the user must write them only while idle, unenforced by the block.
module burst_weighted_three_lane_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  bws_req_if.sink     req_i,
  bws_rsp_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bws_pkg::*;

  logic        in_valid_q, in_valid_d;
  req_t        in_q;
  logic        rsp_valid_q, rsp_valid_d;
  rsp_t        rsp_q;
  rsp_t        rsp_c;
  logic        advance;
  logic        accept;
  logic [4:0]  max_tasks_q;
  logic [31:0] max_bytes_q;
  logic        cfg_we;
  lane_cmd_t   lane_cmd  [NUM_LANES];
  lane_stat_t  lane_stat [NUM_LANES];

  assign advance     = in_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;
  assign in_valid_d  = accept || (in_valid_q && !advance);
  assign rsp_valid_d = advance || (rsp_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (accept) begin
      in_q.func         <= func_e'(req_i.func);
      in_q.priority_req <= lane_e'(req_i.priority_req);
      in_q.cost_bytes   <= req_i.cost_bytes;
      in_q.job_tag      <= req_i.job_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_c;
    end
  end

  // config registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tasks_q <= MAX_TASKS_RST[4:0];
      max_bytes_q <= MAX_BYTES_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_MAX_TASKS) max_tasks_q <= pwdata[4:0];
      if (paddr[2] == REG_MAX_BYTES) max_bytes_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_MAX_BYTES) ? max_bytes_q : 32'(max_tasks_q);

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    bws_lane_fifo u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (lane_cmd[l]),
      .stat_o (lane_stat[l])
    );
  end

  bws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (advance),
    .req_i       (in_q),
    .lane_i      (lane_stat),
    .max_tasks_i (max_tasks_q),
    .max_bytes_i (max_bytes_q),
    .lane_cmd_o  (lane_cmd),
    .rsp_o       (rsp_c)
  );

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_q.status;
  assign rsp_o.task_id       = rsp_q.task_id;
  assign rsp_o.out_tag       = rsp_q.out_tag;
  assign rsp_o.out_lane      = rsp_q.out_lane;
  assign rsp_o.out_cost      = rsp_q.out_cost;
  assign rsp_o.waiting_tasks = rsp_q.waiting_tasks;
  assign rsp_o.waiting_bytes = rsp_q.waiting_bytes;
  assign rsp_o.running_tasks = rsp_q.running_tasks;

endmodule

// ----- rtl/bws_lane_fifo.sv -----
// One lane's circular task store with head pointer and fill count.
module bws_lane_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bws_pkg::lane_cmd_t  cmd_i,
  output bws_pkg::lane_stat_t stat_o
);
  import bws_pkg::*;

  entry_t           mem_q [TASK_SLOTS];
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [POS_W-1:0] pos_sum;
  logic [POS_W-1:0] tail;

  always_comb begin
    pos_sum = POS_W'(head_q) + POS_W'(count_q);
    // wrap the tail position without a modulo
    tail = (pos_sum >= POS_W'(TASK_SLOTS)) ? pos_sum - POS_W'(TASK_SLOTS) : pos_sum;
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.pop) begin
      head_d = (head_q == IDX_W'(TASK_SLOTS - 1)) ? '0 : head_q + IDX_W'(1);
    end
    if (cmd_i.push && !cmd_i.pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop && !cmd_i.push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[tail[IDX_W-1:0]] <= cmd_i.entry;
    end
  end

  assign stat_o.count = count_q;
  assign stat_o.head  = mem_q[head_q];

endmodule

// ----- rtl/bws_ctrl.sv -----
// Admission checks, lane selection and the scheduler's scalar state.
module bws_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  bws_pkg::req_t       req_i,
  input  bws_pkg::lane_stat_t lane_i [bws_pkg::NUM_LANES],
  input  logic [4:0]          max_tasks_i,
  input  logic [31:0]         max_bytes_i,
  output bws_pkg::lane_cmd_t  lane_cmd_o [bws_pkg::NUM_LANES],
  output bws_pkg::rsp_t       rsp_o
);
  import bws_pkg::*;

  logic [CNT_W-1:0] queued_count_q, queued_count_d;
  logic [31:0]      queued_sum_q, queued_sum_d;
  logic [15:0]      running_q, running_d;
  logic [31:0]      next_id_q, next_id_d;
  logic [UR_W-1:0]  urgent_run_q, urgent_run_d;
  logic [NR_W-1:0]  normal_run_q, normal_run_d;

  logic [CNT_W-1:0] sel_cnt;
  logic [31:0]      room;
  logic             slots_full;
  logic             lane_full;
  logic             u_has, n_has, b_has;
  logic             urg_sel, nrm_sel, bg_sel;
  logic             push_ok;
  lane_e            disp_lane;
  entry_t           disp_head;

  always_comb begin
    unique case (req_i.priority_req)
      LANE_BG:      sel_cnt = lane_i[LANE_BG].count;
      LANE_NORMAL:  sel_cnt = lane_i[LANE_NORMAL].count;
      LANE_URGENT:  sel_cnt = lane_i[LANE_URGENT].count;
      LANE_INVALID: sel_cnt = '0;
    endcase
  end

  always_comb begin
    room       = (max_bytes_i > queued_sum_q) ? max_bytes_i - queued_sum_q : '0;
    slots_full = (32'(queued_count_q) >= 32'(max_tasks_i)) ||
                 (32'(queued_count_q) >= 32'(TASK_SLOTS));
    lane_full  = 32'(sel_cnt) >= 32'(TASK_SLOTS);
  end

  // urgent wins until its burst is spent, unless it is the only lane left
  always_comb begin
    u_has   = lane_i[LANE_URGENT].count != '0;
    n_has   = lane_i[LANE_NORMAL].count != '0;
    b_has   = lane_i[LANE_BG].count != '0;
    urg_sel = u_has && ((urgent_run_q < UR_W'(URG_RUN_MAX)) || (!n_has && !b_has));
    nrm_sel = !urg_sel && n_has && ((normal_run_q < NR_W'(NRM_RUN_MAX)) || !b_has);
    bg_sel  = !urg_sel && !nrm_sel && b_has;
    priority if (urg_sel) begin
      disp_lane = LANE_URGENT;
      disp_head = lane_i[LANE_URGENT].head;
    end else if (nrm_sel) begin
      disp_lane = LANE_NORMAL;
      disp_head = lane_i[LANE_NORMAL].head;
    end else begin
      disp_lane = LANE_BG;
      disp_head = lane_i[LANE_BG].head;
    end
  end

  always_comb begin
    queued_count_d = queued_count_q;
    queued_sum_d   = queued_sum_q;
    running_d      = running_q;
    next_id_d      = next_id_q;
    urgent_run_d   = urgent_run_q;
    normal_run_d   = normal_run_q;
    push_ok        = 1'b0;
    rsp_o.status   = ST_INVALID;
    rsp_o.task_id  = '0;
    rsp_o.out_tag  = '0;
    rsp_o.out_lane = '0;
    rsp_o.out_cost = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_cmd_o[l].push  = 1'b0;
      lane_cmd_o[l].pop   = 1'b0;
      lane_cmd_o[l].entry = '{tag: req_i.job_tag, cost: req_i.cost_bytes, id: next_id_q};
    end

    unique case (req_i.func)
      FUNC_SUBMIT: begin
        priority if (req_i.cost_bytes == '0) begin
          rsp_o.status = ST_INVALID;
        end else if (req_i.cost_bytes > max_bytes_i) begin
          rsp_o.status = ST_BUDGET;
        end else if (req_i.priority_req == LANE_INVALID) begin
          rsp_o.status = ST_INVALID;
        end else if (slots_full || (req_i.cost_bytes > room) || lane_full) begin
          rsp_o.status = ST_FULL;
        end else begin
          push_ok        = 1'b1;
          rsp_o.status   = ST_OK;
          rsp_o.task_id  = next_id_q;
          rsp_o.out_lane = req_i.priority_req;
          next_id_d      = (next_id_q == '1) ? 32'd1 : next_id_q + 32'd1;
          queued_count_d = queued_count_q + CNT_W'(1);
          queued_sum_d   = queued_sum_q + req_i.cost_bytes;
        end
        for (int l = 0; l < NUM_LANES; l++) begin
          lane_cmd_o[l].push = go_i && push_ok && (req_i.priority_req == lane_e'(l));
        end
      end
      FUNC_DISPATCH: begin
        if (!(urg_sel || nrm_sel || bg_sel)) begin
          rsp_o.status = ST_EMPTY;
        end else begin
          rsp_o.status   = ST_OK;
          rsp_o.task_id  = disp_head.id;
          rsp_o.out_tag  = disp_head.tag;
          rsp_o.out_cost = disp_head.cost;
          rsp_o.out_lane = disp_lane;
          queued_count_d = queued_count_q - CNT_W'(1);
          queued_sum_d   = queued_sum_q - disp_head.cost;
          if (running_q != '1) running_d = running_q + 16'd1;
          unique case (disp_lane)
            LANE_URGENT: begin
              if (urgent_run_q < UR_W'(URG_RUN_MAX)) urgent_run_d = urgent_run_q + UR_W'(1);
            end
            LANE_NORMAL: begin
              urgent_run_d = '0;
              if (normal_run_q < NR_W'(NRM_RUN_MAX)) normal_run_d = normal_run_q + NR_W'(1);
            end
            LANE_BG, LANE_INVALID: begin
              urgent_run_d = '0;
              normal_run_d = '0;
            end
          endcase
          for (int l = 0; l < NUM_LANES; l++) begin
            lane_cmd_o[l].pop = go_i && (disp_lane == lane_e'(l));
          end
        end
      end
      FUNC_COMPLETE: begin
        if (running_q != '0) begin
          rsp_o.status = ST_OK;
          running_d    = running_q - 16'd1;
        end
      end
      FUNC_INVALID: begin
        rsp_o.status = ST_INVALID;
      end
    endcase

    rsp_o.waiting_tasks = 5'(queued_count_d);
    rsp_o.waiting_bytes = queued_sum_d;
    rsp_o.running_tasks = running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_count_q <= '0;
      queued_sum_q   <= '0;
      running_q      <= '0;
      next_id_q      <= 32'd1;
      urgent_run_q   <= '0;
      normal_run_q   <= '0;
    end else if (go_i) begin
      queued_count_q <= queued_count_d;
      queued_sum_q   <= queued_sum_d;
      running_q      <= running_d;
      next_id_q      <= next_id_d;
      urgent_run_q   <= urgent_run_d;
      normal_run_q   <= normal_run_d;
    end
  end

endmodule

// ----- rtl/bws_checker.sv -----
// Port-level checks on the scheduler, bound to the top level.
module bws_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  status_i,
  input logic [31:0] task_id_i,
  input logic [15:0] out_tag_i,
  input logic [1:0]  out_lane_i,
  input logic [31:0] out_cost_i,
  input logic [4:0]  waiting_tasks_i
);
  import bws_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) && $stable(task_id_i))
    else $error("stalled result changed");

  // an accepted transaction shows its result when the response side is ready
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) ##1 rsp_ready_i |=> rsp_valid_i)
    else $error("result missing after accepted transaction");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_EMPTY) |-> waiting_tasks_i == '0)
    else $error("nothing queued reported with tasks waiting");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != ST_OK) |->
      (task_id_i == '0) && (out_tag_i == '0) && (out_cost_i == '0) && (out_lane_i == '0))
    else $error("rejected transaction carries task fields");

  a_dispatch_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_OK) && (out_cost_i != '0) |-> task_id_i != '0)
    else $error("dispatched task without id");

endmodule

bind burst_weighted_three_lane_scheduler bws_checker u_bws_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .task_id_i       (rsp_o.task_id),
  .out_tag_i       (rsp_o.out_tag),
  .out_lane_i      (rsp_o.out_lane),
  .out_cost_i      (rsp_o.out_cost),
  .waiting_tasks_i (rsp_o.waiting_tasks)
);

// ----- sim/sched_result_checker.sv -----
// Scheduler checker: tracks config writes, predicts each response and compares it.
module sched_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  bws_req_if          req_mon,
  bws_rsp_if          rsp_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  output int unsigned error_count,
  output int unsigned pending_count
);
  import bws_pkg::*;

  logic [15:0]      slot_tag  [NUM_LANES][TASK_SLOTS];
  logic [31:0]      slot_cost [NUM_LANES][TASK_SLOTS];
  logic [31:0]      slot_id   [NUM_LANES][TASK_SLOTS];
  logic [IDX_W-1:0] head      [NUM_LANES];
  logic [CNT_W-1:0] depth     [NUM_LANES];
  logic [4:0]       waiting_cnt;
  logic [31:0]      waiting_sum;
  logic [15:0]      running_cnt;
  logic [31:0]      id_next;
  logic [2:0]       urgent_streak;
  logic [1:0]       normal_streak;
  logic [4:0]       cap_tasks;
  logic [31:0]      cap_bytes;

  rsp_t awaited_results[$];

  // Apply one request to the scheduler state and build the response it produces.
  task automatic schedule_request(input logic [1:0] fn, input logic [1:0] pri,
                                  input logic [31:0] cost, input logic [15:0] tag,
                                  output rsp_t res);
    logic [4:0]       lim;
    logic [31:0]      room;
    logic [IDX_W-1:0] pos;
    int               ln;
    res = '0;
    res.status = ST_OK;
    ln = -1;
    case (fn)
      FUNC_SUBMIT: begin
        lim  = (cap_tasks < TASK_SLOTS) ? cap_tasks : 5'(TASK_SLOTS);
        room = (cap_bytes > waiting_sum) ? cap_bytes - waiting_sum : 32'd0;
        if (cost == 32'd0) begin
          res.status = ST_INVALID;
        end else if (cost > cap_bytes) begin
          res.status = ST_BUDGET;
        end else if (pri == LANE_INVALID) begin
          res.status = ST_INVALID;
        end else if (waiting_cnt >= lim || cost > room || depth[pri] >= TASK_SLOTS) begin
          res.status = ST_FULL;
        end else begin
          pos = head[pri] + depth[pri][IDX_W-1:0];
          slot_tag[pri][pos]  = tag;
          slot_cost[pri][pos] = cost;
          slot_id[pri][pos]   = id_next;
          res.task_id  = id_next;
          res.out_lane = pri;
          id_next      = (id_next == 32'hFFFF_FFFF) ? 32'd1 : id_next + 32'd1;
          depth[pri]   = depth[pri] + 1'b1;
          waiting_cnt  = waiting_cnt + 5'd1;
          waiting_sum  = waiting_sum + cost;
        end
      end
      FUNC_DISPATCH: begin
        if (depth[LANE_URGENT] != 0 && (urgent_streak < URG_RUN_MAX ||
            (depth[LANE_NORMAL] == 0 && depth[LANE_BG] == 0))) begin
          ln = LANE_URGENT;
          if (urgent_streak < URG_RUN_MAX) urgent_streak = urgent_streak + 3'd1;
        end else if (depth[LANE_NORMAL] != 0 &&
                     (normal_streak < NRM_RUN_MAX || depth[LANE_BG] == 0)) begin
          ln = LANE_NORMAL;
          urgent_streak = '0;
          if (normal_streak < NRM_RUN_MAX) normal_streak = normal_streak + 2'd1;
        end else if (depth[LANE_BG] != 0) begin
          ln = LANE_BG;
          urgent_streak = '0;
          normal_streak = '0;
        end
        if (ln < 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.task_id  = slot_id[ln][head[ln]];
          res.out_tag  = slot_tag[ln][head[ln]];
          res.out_cost = slot_cost[ln][head[ln]];
          res.out_lane = 2'(ln);
          waiting_sum  = waiting_sum - slot_cost[ln][head[ln]];
          head[ln]     = head[ln] + 1'b1;
          depth[ln]    = depth[ln] - 1'b1;
          waiting_cnt  = waiting_cnt - 5'd1;
          if (running_cnt != 16'hFFFF) running_cnt = running_cnt + 16'd1;
        end
      end
      FUNC_COMPLETE: begin
        if (running_cnt == 16'd0) res.status = ST_INVALID;
        else running_cnt = running_cnt - 16'd1;
      end
      default: res.status = ST_INVALID;
    endcase
    res.waiting_tasks = waiting_cnt;
    res.waiting_bytes = waiting_sum;
    res.running_tasks = running_cnt;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t        got;
    rsp_t        want;
    logic [31:0] reg_want;
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        head[l]  = '0;
        depth[l] = '0;
      end
      waiting_cnt   = '0;
      waiting_sum   = '0;
      running_cnt   = '0;
      id_next       = 32'd1;
      urgent_streak = '0;
      normal_streak = '0;
      cap_tasks     = MAX_TASKS_RST[4:0];
      cap_bytes     = MAX_BYTES_RST;
      awaited_results.delete();
      error_count   = 0;
      pending_count = 0;
    end else begin
      // register read data shows the value held before this access
      if (psel && penable && pready) begin
        reg_want = (paddr[2] == REG_MAX_TASKS) ? {27'd0, cap_tasks} : cap_bytes;
        if (prdata !== reg_want) begin
          if (error_count < 10)
            $display("register mismatch addr %0d exp %h got %h", paddr, reg_want, prdata);
          error_count = error_count + 1;
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MAX_TASKS) cap_tasks = pwdata[4:0];
        else cap_bytes = pwdata;
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status        = status_e'(rsp_mon.status);
        got.task_id       = rsp_mon.task_id;
        got.out_tag       = rsp_mon.out_tag;
        got.out_lane      = rsp_mon.out_lane;
        got.out_cost      = rsp_mon.out_cost;
        got.waiting_tasks = rsp_mon.waiting_tasks;
        got.waiting_bytes = rsp_mon.waiting_bytes;
        got.running_tasks = rsp_mon.running_tasks;
        if (awaited_results.size() == 0) begin
          if (error_count < 10)
            $display("unexpected response: status %0d id %0d tag %h lane %0d cost %0d",
                     got.status, got.task_id, got.out_tag, got.out_lane, got.out_cost);
          error_count = error_count + 1;
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (got.status !== want.status || got.task_id !== want.task_id ||
              got.out_tag !== want.out_tag || got.out_lane !== want.out_lane ||
              got.out_cost !== want.out_cost || got.waiting_tasks !== want.waiting_tasks ||
              got.waiting_bytes !== want.waiting_bytes ||
              got.running_tasks !== want.running_tasks) begin
            if (error_count < 10) begin
              $display("mismatch exp: st %0d id %0d tag %h lane %0d cost %0d wt %0d wb %0d run %0d",
                       want.status, want.task_id, want.out_tag, want.out_lane, want.out_cost,
                       want.waiting_tasks, want.waiting_bytes, want.running_tasks);
              $display("         got: st %0d id %0d tag %h lane %0d cost %0d wt %0d wb %0d run %0d",
                       got.status, got.task_id, got.out_tag, got.out_lane, got.out_cost,
                       got.waiting_tasks, got.waiting_bytes, got.running_tasks);
            end
            error_count = error_count + 1;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        schedule_request(req_mon.func, req_mon.priority_req, req_mon.cost_bytes,
                         req_mon.job_tag, want);
        awaited_results.insert(awaited_results.size(), want);
      end
      pending_count = awaited_results.size();
    end
  end

endmodule

// ----- sim/tb_burst_weighted_three_lane_scheduler.sv -----
// Testbench top for the three-lane scheduler: stimulus, config writes, watchdog, verdict.
module tb_burst_weighted_three_lane_scheduler;
  import bws_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int          SEGMENTS    = 8;
  localparam int          SEG_ITEMS   = 190;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  bws_req_if req_ch ();
  bws_rsp_if rsp_ch ();

  always #5 clk_i = ~clk_i;

  burst_weighted_three_lane_scheduler uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sched_result_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // Response side backpressure.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("burst_weighted_three_lane_scheduler test failed");
      $finish;
    end
  end

  // Enter and leave at a falling edge; valid stays high into the next request.
  task automatic send_request(input logic [1:0] fn, input logic [1:0] pri,
                              input logic [31:0] cost, input logic [15:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid        = 1'b1;
    req_ch.func         = fn;
    req_ch.priority_req = pri;
    req_ch.cost_bytes   = cost;
    req_ch.job_tag      = tag;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    req_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic reg_idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin
    logic [1:0]  fn;
    logic [1:0]  pri;
    logic [31:0] cost;
    logic [4:0]  cur_tasks;
    logic [31:0] cur_bytes;
    int          r;
    req_ch.valid        = 1'b0;
    req_ch.func         = FUNC_SUBMIT;
    req_ch.priority_req = LANE_BG;
    req_ch.cost_bytes   = '0;
    req_ch.job_tag      = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Corner requests on an empty scheduler at reset limits.
    send_request(FUNC_DISPATCH, LANE_BG, 32'd0, 16'h0000);
    send_request(FUNC_COMPLETE, LANE_BG, 32'd0, 16'h0000);
    send_request(FUNC_INVALID, LANE_INVALID, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(FUNC_SUBMIT, LANE_URGENT, 32'd0, 16'h1234);
    send_request(FUNC_SUBMIT, LANE_INVALID, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(FUNC_SUBMIT, LANE_INVALID, 32'd1, 16'h0001);
    send_request(FUNC_SUBMIT, LANE_URGENT, MAX_BYTES_RST, 16'hFFFF);
    send_request(FUNC_SUBMIT, LANE_BG, 32'd1, 16'h0002);
    send_request(FUNC_DISPATCH, LANE_BG, 32'd0, 16'h0000);
    // Fill lanes so dispatch walks through both burst limits.
    for (int i = 0; i < 5; i++) send_request(FUNC_SUBMIT, LANE_URGENT, 32'(100 + i), 16'(i));
    for (int i = 0; i < 3; i++) send_request(FUNC_SUBMIT, LANE_NORMAL, 32'(200 + i), 16'(16 + i));
    send_request(FUNC_SUBMIT, LANE_BG, 32'd300, 16'h8000);
    for (int i = 0; i < 9; i++) send_request(FUNC_DISPATCH, LANE_BG, 32'd0, 16'h0000);
    send_request(FUNC_COMPLETE, LANE_BG, 32'd0, 16'h0000);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      repeat (4) @(negedge clk_i);
      case (seg)
        0: begin cur_tasks = 5'd16; cur_bytes = 32'd1048576;    end
        1: begin cur_tasks = 5'd1;  cur_bytes = 32'd1;          end
        2: begin cur_tasks = 5'd31; cur_bytes = 32'hFFFF_FFFF;  end
        3: begin cur_tasks = 5'd0;  cur_bytes = 32'd1000;       end
        4: begin cur_tasks = 5'd4;  cur_bytes = 32'd0;          end
        5: begin cur_tasks = 5'd16; cur_bytes = 32'd5000;       end
        6: begin cur_tasks = 5'd20; cur_bytes = 32'h8000_0000;  end
        default: begin cur_tasks = 5'd8; cur_bytes = 32'd300;   end
      endcase
      reg_write(REG_MAX_TASKS, {27'd0, cur_tasks});
      reg_write(REG_MAX_BYTES, cur_bytes);
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // Hold off mid-segment until every response is back.
        if (n == SEG_ITEMS / 2) drain_results();
        r = $urandom_range(99);
        if (r < 42) fn = FUNC_SUBMIT;
        else if (r < 77) fn = FUNC_DISPATCH;
        else if (r < 95) fn = FUNC_COMPLETE;
        else fn = FUNC_INVALID;
        pri = ($urandom_range(19) == 0) ? 2'(LANE_INVALID) : 2'($urandom_range(2));
        case ($urandom_range(9))
          0: cost = 32'd0;
          1: cost = $urandom;
          2: cost = cur_bytes;
          3: cost = cur_bytes + 32'd1;
          default: cost = $urandom_range((cur_bytes > 32'd3) ? cur_bytes / 4 : 32'd1, 1);
        endcase
        send_request(fn, pri, cost, 16'($urandom));
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("burst_weighted_three_lane_scheduler test passed");
    end else begin
      $display("burst_weighted_three_lane_scheduler test failed");
    end
    $finish;
  end

endmodule
